/* design/bsa_pkg.sv */
// Shared types, sizes and lane helpers for the banked SRAM port arbiter.
package bsa_pkg;

    localparam int ROW_COUNT_DEF  = 256;
    localparam int BANK_COUNT     = 4;
    localparam int SUB_BANK_COUNT = 2;
    localparam int ELEMS_PER_ROW  = 4;
    localparam int ELEM_BITS      = 16;

    localparam int ROW_BITS  = ELEMS_PER_ROW * ELEM_BITS;
    localparam int SUB_BITS  = (ELEMS_PER_ROW / SUB_BANK_COUNT) * ELEM_BITS;
    localparam int ROW_W     = 9;
    localparam int MASK_W    = 2;
    localparam int SUB_W     = 2;
    localparam int LANE_W    = (SUB_BANK_COUNT > 1) ? $clog2(SUB_BANK_COUNT) : 1;

    typedef logic [ROW_W-1:0]    row_idx_t;
    typedef logic [MASK_W-1:0]   mask_t;
    typedef logic [SUB_W-1:0]    sub_t;
    typedef logic [LANE_W-1:0]   lane_idx_t;
    typedef logic [ROW_BITS-1:0] row_word_t;
    typedef logic [SUB_BITS-1:0] lane_word_t;

    // Ready flags and data-moving enables of one item, decided at accept.
    typedef struct packed {
        logic fr_ready;
        logic nr_ready;
        logic fw_ready;
        logic nw_ready;
        logic fr_en;
        logic nr_en;
        logic fw_en;
        logic nw_en;
    } grant_t;

    // Replace the lanes selected by mask with those of src.
    function automatic row_word_t merge_lanes(row_word_t base, row_word_t src, mask_t mask);
        row_word_t res;
        res = base;
        for (int s = 0; s < SUB_BANK_COUNT && s < MASK_W; s++) begin
            if (mask[s])
            begin
                res[s*SUB_BITS +: SUB_BITS] = src[s*SUB_BITS +: SUB_BITS];
            end
        end
        return res;
    endfunction

    function automatic lane_word_t get_lane(row_word_t word, lane_idx_t idx);
        return word[idx*SUB_BITS +: SUB_BITS];
    endfunction

    function automatic row_word_t put_lane(row_word_t word, lane_idx_t idx, lane_word_t data);
        row_word_t res;
        res = word;
        res[idx*SUB_BITS +: SUB_BITS] = data;
        return res;
    endfunction

endpackage

/* design/bsa_ram.sv */
// Generic single-write, dual-read synchronous RAM with registered read data.
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_a_reg <= mem_reg[raddr_a];
        rdata_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

/* design/bsa_arb.sv */
// Read and write port arbitration over bank/sub-bank pairs for one item.
module bsa_arb #(
    parameter int ROW_COUNT = bsa_pkg::ROW_COUNT_DEF
) (
    input  bsa_pkg::row_idx_t fr_row,
    input  bsa_pkg::mask_t    fr_mask,
    input  logic              nr_valid,
    input  bsa_pkg::row_idx_t nr_row,
    input  bsa_pkg::sub_t     nr_sub,
    input  bsa_pkg::row_idx_t fw_row,
    input  bsa_pkg::mask_t    fw_mask,
    input  logic              nw_valid,
    input  bsa_pkg::row_idx_t nw_row,
    input  bsa_pkg::sub_t     nw_sub,
    output bsa_pkg::grant_t   grant
);
    import bsa_pkg::*;

    localparam row_idx_t BANK_MASK = ROW_W'(BANK_COUNT - 1);

    logic      fr_in, nr_in, fw_in, nw_in;
    logic      nr_sub_ok, nw_sub_ok;
    logic      nr_taken, nw_taken;
    lane_idx_t nr_lane, nw_lane;

    always_comb
    begin
        fr_in     = 32'(fr_row) < ROW_COUNT;
        nr_in     = 32'(nr_row) < ROW_COUNT;
        fw_in     = 32'(fw_row) < ROW_COUNT;
        nw_in     = 32'(nw_row) < ROW_COUNT;
        nr_sub_ok = 32'(nr_sub) < SUB_BANK_COUNT;
        nw_sub_ok = 32'(nw_sub) < SUB_BANK_COUNT;
        nr_lane   = LANE_W'(nr_sub);
        nw_lane   = LANE_W'(nw_sub);

        // The full port claims first; the narrow port loses a pair it shares.
        nr_taken = fr_in && fr_mask[nr_lane] && (((fr_row ^ nr_row) & BANK_MASK) == '0);
        nw_taken = fw_in && fw_mask[nw_lane] && (((fw_row ^ nw_row) & BANK_MASK) == '0);

        grant.fr_ready = fr_in;
        grant.fw_ready = fw_in;
        grant.nr_ready = nr_in && nr_sub_ok && !nr_taken;
        grant.nw_ready = nw_in && nw_sub_ok && !nw_taken;
        grant.fr_en    = fr_in && (fr_mask != '0);
        grant.fw_en    = fw_in && (fw_mask != '0);
        grant.nr_en    = nr_valid && nr_in && nr_sub_ok && !nr_taken;
        grant.nw_en    = nw_valid && nw_in && nw_sub_ok && !nw_taken;
    end

endmodule

/* design/banked_sram_port_arbiter_core.sv */
// Top level of the banked SRAM port arbiter: sequencer, read registers and row store.
//
// Usage: one input transfer carries a full-row read, a narrow read, a full-row write
// and a narrow write request. Each accepted item yields one output transfer with the
// four ready flags and the full and narrow read data registers as they stood before
// the item (read data therefore shows one item later).
// Both channels use valid/stall; a transfer happens when valid is high and stall low.
// Sequence: the accept addresses the read rows, then read data return with the write rows
// addressed, full-row write, narrow write, result load. The single write port of the row
// store and the read-modify-write of masked lanes set this sequence; a new item is taken
// only once the sequencer is back in idle.
// The next item is accepted while a finished result still waits at the output; the
// sequencer then holds in its last step until the receiver drops stall.
// Reset clears the sequencer, the output valid and both read data registers to zero;
// the row store is not cleared and a row never written reads as undefined data.
module banked_sram_port_arbiter_core #(
    parameter int ROW_COUNT = bsa_pkg::ROW_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  bsa_pkg::row_idx_t    full_read_row,
    input  bsa_pkg::mask_t       full_read_mask,
    input  logic                 narrow_read_valid,
    input  bsa_pkg::row_idx_t    narrow_read_row,
    input  bsa_pkg::sub_t        narrow_read_sub,
    input  bsa_pkg::row_idx_t    full_write_row,
    input  bsa_pkg::mask_t       full_write_mask,
    input  bsa_pkg::row_word_t   full_write_data,
    input  logic                 narrow_write_valid,
    input  bsa_pkg::row_idx_t    narrow_write_row,
    input  bsa_pkg::sub_t        narrow_write_sub,
    input  bsa_pkg::lane_word_t  narrow_write_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 full_read_ready,
    output logic                 narrow_read_ready,
    output logic                 full_write_ready,
    output logic                 narrow_write_ready,
    output bsa_pkg::row_word_t   full_read_result,
    output bsa_pkg::lane_word_t  narrow_read_result
);
    import bsa_pkg::*;

    localparam int ADDR_W = $clog2(ROW_COUNT);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_RDATA   = 3'd1;
    localparam logic [2:0] ST_WFULL   = 3'd2;
    localparam logic [2:0] ST_WNARROW = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       in_accept;
    logic       out_load;
    logic       out_valid_reg, out_valid_next;

    grant_t     grant;
    grant_t     grant_reg;
    mask_t      fr_mask_reg, fw_mask_reg;
    lane_idx_t  nr_lane_reg, nw_lane_reg;
    row_idx_t   fw_row_reg, nw_row_reg;
    row_word_t  fw_data_reg;
    lane_word_t nw_data_reg;

    row_word_t  full_read_reg;
    lane_word_t narrow_read_reg;
    row_word_t  fr_new_reg;
    lane_word_t nr_new_reg;
    row_word_t  nw_word_reg;

    logic              out_fr_ready_reg, out_nr_ready_reg;
    logic              out_fw_ready_reg, out_nw_ready_reg;
    row_word_t         out_full_reg;
    lane_word_t        out_narrow_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
    row_word_t         ram_wdata, ram_rdata_a, ram_rdata_b;
    row_word_t         fw_merged, nw_base;

    bsa_arb #(
        .ROW_COUNT (ROW_COUNT)
    ) u_arb (
        .fr_row   (full_read_row),
        .fr_mask  (full_read_mask),
        .nr_valid (narrow_read_valid),
        .nr_row   (narrow_read_row),
        .nr_sub   (narrow_read_sub),
        .fw_row   (full_write_row),
        .fw_mask  (full_write_mask),
        .nw_valid (narrow_write_valid),
        .nw_row   (narrow_write_row),
        .nw_sub   (narrow_write_sub),
        .grant    (grant)
    );

    bsa_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (ROW_COUNT)
    ) u_row_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        // Full write merges into the old row; a narrow write to the same row
        // must see that merged word, so forward it.
        fw_merged = merge_lanes(ram_rdata_a, fw_data_reg, fw_mask_reg);
        nw_base   = (grant_reg.fw_en && (fw_row_reg == nw_row_reg)) ? fw_merged : ram_rdata_b;

        ram_raddr_a = ADDR_W'(fw_row_reg);
        ram_raddr_b = ADDR_W'(nw_row_reg);
        if (state_reg == ST_IDLE)
        begin
            ram_raddr_a = ADDR_W'(full_read_row);
            ram_raddr_b = ADDR_W'(narrow_read_row);
        end

        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(fw_row_reg);
        ram_wdata = fw_merged;
        case (state_reg)
            ST_WFULL:
            begin
                ram_we = grant_reg.fw_en;
            end
            ST_WNARROW:
            begin
                ram_we    = grant_reg.nw_en;
                ram_waddr = ADDR_W'(nw_row_reg);
                ram_wdata = nw_word_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA:   state_next = ST_WFULL;
            ST_WFULL:   state_next = ST_WNARROW;
            ST_WNARROW: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            full_read_reg   <= '0;
            narrow_read_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (out_load)
            begin
                full_read_reg   <= fr_new_reg;
                narrow_read_reg <= nr_new_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            grant_reg   <= grant;
            fr_mask_reg <= full_read_mask;
            nr_lane_reg <= LANE_W'(narrow_read_sub);
            fw_row_reg  <= full_write_row;
            fw_mask_reg <= full_write_mask;
            fw_data_reg <= full_write_data;
            nw_row_reg  <= narrow_write_row;
            nw_lane_reg <= LANE_W'(narrow_write_sub);
            nw_data_reg <= narrow_write_data;
        end

        // Read data returns in the cycle after accept: stage the new register values.
        if (state_reg == ST_RDATA)
        begin
            fr_new_reg <= grant_reg.fr_en ?
                          merge_lanes(full_read_reg, ram_rdata_a, fr_mask_reg) : full_read_reg;
            nr_new_reg <= grant_reg.nr_en ? get_lane(ram_rdata_b, nr_lane_reg) : narrow_read_reg;
        end

        if (state_reg == ST_WFULL)
        begin
            nw_word_reg <= put_lane(nw_base, nw_lane_reg, nw_data_reg);
        end

        if (out_load)
        begin
            out_fr_ready_reg <= grant_reg.fr_ready;
            out_nr_ready_reg <= grant_reg.nr_ready;
            out_fw_ready_reg <= grant_reg.fw_ready;
            out_nw_ready_reg <= grant_reg.nw_ready;
            out_full_reg     <= full_read_reg;
            out_narrow_reg   <= narrow_read_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign full_read_ready    = out_fr_ready_reg;
    assign narrow_read_ready  = out_nr_ready_reg;
    assign full_write_ready   = out_fw_ready_reg;
    assign narrow_write_ready = out_nw_ready_reg;
    assign full_read_result   = out_full_reg;
    assign narrow_read_result = out_narrow_reg;

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_RDATA))
        else $error("accepted item did not advance to read data step");

    a_write_only_in_write_steps: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((state_reg == ST_WFULL) || (state_reg == ST_WNARROW)))
        else $error("row store written outside a write step");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result shown without finishing an item");

    a_no_lane_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WFULL) && grant_reg.fw_en && grant_reg.nw_en &&
         (fw_row_reg == nw_row_reg)) |-> !fw_mask_reg[nw_lane_reg])
        else $error("full and narrow writes granted on the same lane");

    a_regs_hold_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_DONE) && $past(state_reg != ST_DONE)) |->
        ($stable(full_read_reg) && $stable(narrow_read_reg)))
        else $error("read data register changed outside result load");

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the banked SRAM port arbiter core.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bsa_pkg::*;

    localparam int ROWS             = ROW_COUNT_DEF;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int DRAIN_CYCLES     = 20;
    localparam int PHASE_ITEMS      = 320;

    typedef struct packed {
        row_idx_t   fr_row;
        mask_t      fr_mask;
        logic       nr_valid;
        row_idx_t   nr_row;
        sub_t       nr_sub;
        row_idx_t   fw_row;
        mask_t      fw_mask;
        row_word_t  fw_data;
        logic       nw_valid;
        row_idx_t   nw_row;
        sub_t       nw_sub;
        lane_word_t nw_data;
    } port_req_t;

    typedef struct packed {
        logic       fr_ready;
        logic       nr_ready;
        logic       fw_ready;
        logic       nw_ready;
        row_word_t  fr_data;
        lane_word_t nr_data;
    } port_resp_t;

    typedef struct packed {
        port_req_t  req;
        logic       typed;
        port_resp_t want;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    row_idx_t   full_read_row;
    mask_t      full_read_mask;
    logic       narrow_read_valid;
    row_idx_t   narrow_read_row;
    sub_t       narrow_read_sub;
    row_idx_t   full_write_row;
    mask_t      full_write_mask;
    row_word_t  full_write_data;
    logic       narrow_write_valid;
    row_idx_t   narrow_write_row;
    sub_t       narrow_write_sub;
    lane_word_t narrow_write_data;
    logic       out_valid;
    logic       out_stall;
    logic       full_read_ready;
    logic       narrow_read_ready;
    logic       full_write_ready;
    logic       narrow_write_ready;
    row_word_t  full_read_result;
    lane_word_t narrow_read_result;

    // Shadow copy of the scratchpad and its read registers
    row_word_t                 shadow_rows [ROWS];
    logic [SUB_BANK_COUNT-1:0] lane_written [ROWS];
    row_word_t                 shadow_full_rd;
    lane_word_t                shadow_narrow_rd;

    port_resp_t responses_due [$];
    port_resp_t next_due;
    stim_row_t  directed_rows [$];
    stim_row_t  scratch_row;

    int   mismatch_count = 0;
    int   result_count = 0;
    int   cycle_count = 0;
    int   in_idle_pct;
    int   out_stall_pct;
    logic long_hold_pending;
    logic long_hold_done = 1'b0;

    banked_sram_port_arbiter_core i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // A narrow port gets its pair unless the full port of the same side claimed it.
    function automatic logic narrow_free(row_idx_t full_row, mask_t full_mask,
                                         row_idx_t row, sub_t sub);
        return row < ROWS && sub < SUB_BANK_COUNT
            && !(full_row < ROWS && (full_row % BANK_COUNT) == (row % BANK_COUNT)
                 && full_mask[sub]);
    endfunction

    // Keep reads off lanes that were never written.
    function automatic port_req_t avoid_unwritten(port_req_t r);
        if (r.fr_row < ROWS)
            r.fr_mask = r.fr_mask & lane_written[r.fr_row];
        if (r.nr_valid && narrow_free(r.fr_row, r.fr_mask, r.nr_row, r.nr_sub)
            && !lane_written[r.nr_row][r.nr_sub])
            r.nr_valid = 1'b0;
        return r;
    endfunction

    function automatic port_resp_t serve_requests(port_req_t r);
        port_resp_t o;
        o.fr_ready = r.fr_row < ROWS;
        o.nr_ready = narrow_free(r.fr_row, r.fr_mask, r.nr_row, r.nr_sub);
        o.fw_ready = r.fw_row < ROWS;
        o.nw_ready = narrow_free(r.fw_row, r.fw_mask, r.nw_row, r.nw_sub);
        o.fr_data  = shadow_full_rd;
        o.nr_data  = shadow_narrow_rd;
        // reads see the rows as they stood before this item's writes
        if (o.fr_ready)
            for (int s = 0; s < SUB_BANK_COUNT; s++)
                if (r.fr_mask[s])
                    shadow_full_rd[s*SUB_BITS +: SUB_BITS] =
                        shadow_rows[r.fr_row][s*SUB_BITS +: SUB_BITS];
        if (r.nr_valid && o.nr_ready)
            shadow_narrow_rd = shadow_rows[r.nr_row][r.nr_sub*SUB_BITS +: SUB_BITS];
        if (o.fw_ready)
            for (int s = 0; s < SUB_BANK_COUNT; s++)
                if (r.fw_mask[s])
                begin
                    shadow_rows[r.fw_row][s*SUB_BITS +: SUB_BITS] =
                        r.fw_data[s*SUB_BITS +: SUB_BITS];
                    lane_written[r.fw_row][s] = 1'b1;
                end
        if (r.nw_valid && o.nw_ready)
        begin
            shadow_rows[r.nw_row][r.nw_sub*SUB_BITS +: SUB_BITS] = r.nw_data;
            lane_written[r.nw_row][r.nw_sub] = 1'b1;
        end
        return o;
    endfunction

    function automatic void check_field(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
        begin
            if (mismatch_count < 10)
                $display("mismatch in %s of result %0d: expected %h, got %h",
                         what, result_count, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (responses_due.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("result %0d arrived with nothing outstanding", result_count);
                mismatch_count++;
            end
            else
            begin
                next_due = responses_due.pop_front();
                check_field("full_read_ready", full_read_ready, next_due.fr_ready);
                check_field("narrow_read_ready", narrow_read_ready, next_due.nr_ready);
                check_field("full_write_ready", full_write_ready, next_due.fw_ready);
                check_field("narrow_write_ready", narrow_write_ready, next_due.nw_ready);
                check_field("full_read_result", full_read_result, next_due.fr_data);
                check_field("narrow_read_result", narrow_read_result, next_due.nr_data);
            end
            result_count++;
        end
    end

    // Output side: random stall, plus one long hold-off to back up the input.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_pending && !long_hold_done)
            begin
                long_hold_done = 1'b1;
                out_stall = 1'b1;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else
                out_stall = $urandom_range(99) < out_stall_pct;
        end
    end

    task automatic add_row(row_idx_t fr_row, mask_t fr_mask, logic nr_valid,
                           row_idx_t nr_row, sub_t nr_sub, row_idx_t fw_row,
                           mask_t fw_mask, row_word_t fw_data, logic nw_valid,
                           row_idx_t nw_row, sub_t nw_sub, lane_word_t nw_data);
        stim_row_t row;
        row = '0;
        row.req = '{fr_row, fr_mask, nr_valid, nr_row, nr_sub, fw_row, fw_mask, fw_data,
                    nw_valid, nw_row, nw_sub, nw_data};
        directed_rows.push_back(row);
    endtask

    // Attach a fixed expectation to the row added last; flags are {fr, nr, fw, nw}.
    task automatic add_typed(logic [3:0] flags, row_word_t fr_data, lane_word_t nr_data);
        stim_row_t row;
        row = directed_rows.pop_back();
        row.typed = 1'b1;
        row.want = {flags, fr_data, nr_data};
        directed_rows.push_back(row);
    endtask

    function automatic row_idx_t pick_row();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 50)
            return row_idx_t'($urandom_range(15));
        if (p < 85)
            return row_idx_t'($urandom_range(ROWS - 1));
        return row_idx_t'($urandom_range(511, ROWS));
    endfunction

    function automatic sub_t pick_sub();
        if ($urandom_range(99) < 85)
            return sub_t'($urandom_range(1));
        return sub_t'($urandom_range(3, 2));
    endfunction

    function automatic row_word_t pick_word();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 10)
            return '0;
        if (p < 20)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic stim_row_t random_row();
        stim_row_t row;
        row_word_t lane_src;
        row = '0;
        row.req.fr_row   = pick_row();
        row.req.fr_mask  = mask_t'($urandom_range(3));
        row.req.nr_valid = $urandom_range(99) < 80;
        row.req.nr_row   = pick_row();
        row.req.nr_sub   = pick_sub();
        row.req.fw_row   = pick_row();
        row.req.fw_mask  = mask_t'($urandom_range(3));
        row.req.fw_data  = pick_word();
        row.req.nw_valid = $urandom_range(99) < 80;
        row.req.nw_row   = pick_row();
        row.req.nw_sub   = pick_sub();
        lane_src         = pick_word();
        row.req.nw_data  = lane_src[SUB_BITS-1:0];
        return row;
    endfunction

    // Entered and left at a falling edge; holds the payload until the transfer.
    task automatic offer(stim_row_t row);
        port_resp_t want;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        row.req            = avoid_unwritten(row.req);
        full_read_row      = row.req.fr_row;
        full_read_mask     = row.req.fr_mask;
        narrow_read_valid  = row.req.nr_valid;
        narrow_read_row    = row.req.nr_row;
        narrow_read_sub    = row.req.nr_sub;
        full_write_row     = row.req.fw_row;
        full_write_mask    = row.req.fw_mask;
        full_write_data    = row.req.fw_data;
        narrow_write_valid = row.req.nw_valid;
        narrow_write_row   = row.req.nw_row;
        narrow_write_sub   = row.req.nw_sub;
        narrow_write_data  = row.req.nw_data;
        in_valid           = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        want = serve_requests(row.req);
        if (row.typed)
            want = row.want;
        responses_due.push_back(want);
        @(negedge clk);
    endtask

    task automatic run_random_phase(int sender_pct, int receiver_pct, int hold_at);
        in_idle_pct   = sender_pct;
        out_stall_pct = receiver_pct;
        for (int i = 0; i < PHASE_ITEMS; i++)
        begin
            if (i == hold_at)
                long_hold_pending = 1'b1;
            offer(random_row());
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        in_valid           = 1'b0;
        full_read_row      = '0;
        full_read_mask     = '0;
        narrow_read_valid  = 1'b0;
        narrow_read_row    = '0;
        narrow_read_sub    = '0;
        full_write_row     = '0;
        full_write_mask    = '0;
        full_write_data    = '0;
        narrow_write_valid = 1'b0;
        narrow_write_row   = '0;
        narrow_write_sub   = '0;
        narrow_write_data  = '0;
        in_idle_pct        = 0;
        out_stall_pct      = 0;
        long_hold_pending  = 1'b0;
        shadow_full_rd     = '0;
        shadow_narrow_rd   = '0;
        for (int r = 0; r < ROWS; r++)
        begin
            shadow_rows[r]  = '0;
            lane_written[r] = '0;
        end

        //       fr   msk nrv nr   sub  fw   msk fw_data                nwv nw   sub nw_data
        add_row(0,   0,  0,  511, 3,   0,   3,  '1,                    1,  1,   0,  '0);
        add_typed(4'b1011, '0, '0);
        add_row(511, 3,  1,  0,   2,   256, 3,  '0,                    1,  4,   1,  '1);
        add_typed(4'b0001, '0, '0);
        add_row(0,   3,  1,  4,   1,   8,   1,  64'h0123_4567_89AB_CDEF, 1, 12,  0,  '0);
        add_typed(4'b1010, '0, '0);
        add_row(4,   2,  1,  1,   0,   1,   2,  64'h0123_4567_89AB_CDEF, 1, 5,   1,  '0);
        add_typed(4'b1110, '1, '0);
        add_row(8,   1,  1,  1,   1,   255, 3,  '0,                    1,  255, 1,  '1);
        add_row(255, 3,  1,  255, 3,   2,   0,  '1,                    1,  2,   0,  32'hA5A5_A5A5);
        add_row(2,   1,  1,  6,   0,   3,   3,  64'h8000_0000_0000_0001, 0, 7,   0,  '0);
        add_row(256, 0,  1,  3,   0,   511, 0,  '0,                    1,  256, 0,  '1);
        add_row(3,   3,  1,  7,   1,   7,   2,  64'hFFFF_0000_FFFF_0000, 1, 7,   0,  32'h1234_5678);
        add_row(7,   3,  1,  2,   0,   0,   1,  '0,                    1,  0,   3,  '0);
        add_row(0,   2,  1,  0,   0,   4,   1,  64'h5555_5555_5555_5555, 1, 8,   1,  '0);
        add_row(0,   0,  0,  0,   0,   0,   0,  '0,                    0,  0,   0,  '0);
        add_row(8,   3,  1,  255, 0,   12,  3,  64'hDEAD_BEEF_CAFE_F00D, 1, 0,   1,  32'h7FFF_FFFF);
        add_row(12,  3,  1,  511, 1,   510, 1,  '1,                    1,  511, 3,  '1);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            scratch_row = directed_rows[i];
            offer(scratch_row);
        end

        run_random_phase(0, 0, 100);
        run_random_phase(51, 0, -1);
        run_random_phase(0, 51, -1);
        run_random_phase(22, 22, -1);
        in_valid = 1'b0;

        while (responses_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
